@@ src/dto_pkg.sv @@
// Shared types, constants and calendar functions for the datetime offset block.
`default_nettype none

package dto_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Calendar range and time constants.
    localparam logic [10:0] YEAR_MIN  = 11'd1900;
    localparam logic [10:0] YEAR_MAX  = 11'd2030;
    localparam int          DAY_SECS  = 86400;
    localparam int          HOUR_SECS = 3600;
    localparam int          MIN_SECS  = 60;
    localparam int          HOURS_PER_DAY = 24;

    // Reciprocals for the constant divisions: q = (x * RECIP) >> SHIFT, exact over the
    // operand widths used. The day split takes the instant divided by 128 (86400 = 128 * 675),
    // the hour split the second of day divided by 16 (3600 = 16 * 225) and the minute
    // split the second of hour divided by 4 (60 = 4 * 15).
    localparam logic [26:0] DAY_RECIP        = 27'd101806633;
    localparam int          DAY_RECIP_SHIFT  = 36;
    localparam logic [13:0] HOUR_RECIP       = 14'd9321;
    localparam int          HOUR_RECIP_SHIFT = 21;
    localparam logic [10:0] MIN_RECIP        = 11'd1093;
    localparam int          MIN_RECIP_SHIFT  = 14;

    // Days from 1/1/1900 through 31/12/2030 (131 years, 32 of them leap).
    localparam int RANGE_DAYS = 131 * 365 + 32;

    // Last representable second of the range, counted from 1/1/1900 00:00:00.
    localparam logic [32:0] T_MAX = 33'(64'(RANGE_DAYS) * 64'(DAY_SECS) - 64'd1);

    // Result of the shared compare and subtract unit.
    typedef struct packed {
        logic        ge;
        logic [32:0] diff;
    } dto_alu_res_t;

    // Leap rule inside 1900..2030: a multiple of four other than 1900.
    // Years outside the range are rejected before this matters.
    function automatic logic is_leap(input logic [10:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_MIN);
    endfunction

    function automatic logic [8:0] days_in_year(input logic [10:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [10:0] y);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = is_leap(y) ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of month m.
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ src/dto_alu.sv @@
// Shared compare and subtract unit used by the subtract and walk steps of the sequencer.
`default_nettype none

module dto_alu
    import dto_pkg::*;
(
    input  wire logic [32:0]  a,
    input  wire logic [32:0]  b,
    output dto_alu_res_t      res
);

    logic [33:0] wide_diff;

    // One wide subtract; the borrow out gives the compare.
    always_comb
    begin
        wide_diff = {1'b0, a} - {1'b0, b};
        res.ge    = ~wide_diff[33];
        res.diff  = wide_diff[32:0];
    end

endmodule

`default_nettype wire

@@ src/datetime_offset_seconds_top.sv @@
// Top level of the datetime offset block: sequencer around a shared compare/subtract unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  in      | in        | in_valid, in_stall | op, day, month, year, hour, minute, second,
//          |           |                    | n_seconds
//  out     | out       | out_valid,out_stall| res_day, res_month, res_year, res_hour,
//          |           |                    | res_minute, res_second, status
//
// An invalid item goes from the check straight to the finishing step. A valid item is set up
// (day count, instant, offset), has the day split off, walks whole years and then months, has
// hour, minute and second split off and ends in the finishing step; the year walk is the longest part.
// in_stall is high from acceptance until the result is loaded into the output register.
// A result held by out_stall keeps the block in its finishing step; reset clears the
// sequencer and the output valid flag asynchronously.
`default_nettype none

module datetime_offset_seconds_top
    import dto_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [4:0]  day,
    input  wire logic [3:0]  month,
    input  wire logic [10:0] year,
    input  wire logic [4:0]  hour,
    input  wire logic [5:0]  minute,
    input  wire logic [5:0]  second,
    input  wire logic [30:0] n_seconds,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       res_day,
    output logic [3:0]       res_month,
    output logic [10:0]      res_year,
    output logic [4:0]       res_hour,
    output logic [5:0]       res_minute,
    output logic [5:0]       res_second,
    output logic [1:0]       status
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DAYS = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_ADD  = 4'd3;
    localparam logic [3:0] S_QDAY = 4'd4;
    localparam logic [3:0] S_RDAY = 4'd5;
    localparam logic [3:0] S_YEAR = 4'd6;
    localparam logic [3:0] S_MON  = 4'd7;
    localparam logic [3:0] S_QHR  = 4'd8;
    localparam logic [3:0] S_RHR  = 4'd9;
    localparam logic [3:0] S_QMIN = 4'd10;
    localparam logic [3:0] S_RMIN = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // Captured input item.
    logic        op_reg, op_next;
    logic [4:0]  day_in_reg, day_in_next;
    logic [3:0]  mon_in_reg, mon_in_next;
    logic [10:0] year_in_reg, year_in_next;
    logic [4:0]  hour_in_reg, hour_in_next;
    logic [5:0]  min_in_reg, min_in_next;
    logic [5:0]  sec_in_reg, sec_in_next;
    logic [30:0] n_reg, n_next;

    // Working registers.
    logic [32:0] acc_reg, acc_next;
    logic [16:0] sod_reg, sod_next;
    logic [15:0] days_reg, days_next;
    logic [10:0] year_reg, year_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [1:0]  status_reg, status_next;

    // Output register.
    logic [4:0]  res_day_reg, res_day_next;
    logic [3:0]  res_month_reg, res_month_next;
    logic [10:0] res_year_reg, res_year_next;
    logic [4:0]  res_hour_reg, res_hour_next;
    logic [5:0]  res_minute_reg, res_minute_next;
    logic [5:0]  res_second_reg, res_second_next;
    logic [1:0]  status_out_reg, status_out_next;

    logic [32:0]  alu_a, alu_b;
    dto_alu_res_t alu_res;

    logic         in_ok;
    logic [7:0]   year_off;
    logic [10:0]  leap_cnt_full;
    logic [5:0]   leap_cnt;
    logic         feb_adj;
    logic [33:0]  sum_add;
    logic [52:0]  day_prod;
    logic [26:0]  hour_prod;
    logic [20:0]  min_prod;
    logic         load_out;

    dto_alu u_alu
    (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_a = acc_reg;
        alu_b = 33'd0;
        case (state_reg)
            S_ADD:  alu_b = {2'b00, n_reg};
            S_RDAY: alu_b = {17'd0, days_reg} * 33'(DAY_SECS);
            S_YEAR:
            begin
                alu_a = {17'd0, days_reg};
                alu_b = {24'd0, days_in_year(year_reg)};
            end
            S_MON:
            begin
                alu_a = {17'd0, days_reg};
                alu_b = {28'd0, days_in_month(mon_reg, year_reg)};
            end
            S_RHR:  alu_b = {28'd0, hour_reg} * 33'(HOUR_SECS);
            S_RMIN: alu_b = {27'd0, min_reg} * 33'(MIN_SECS);
            default: alu_b = 33'd0;
        endcase
    end

    // Validity of the captured item, the terms of its day count from 1/1/1900 and the offset sum.
    always_comb
    begin
        in_ok = (mon_in_reg >= 4'd1) && (mon_in_reg <= 4'd12) &&
                (year_in_reg >= YEAR_MIN) && (year_in_reg <= YEAR_MAX) &&
                (day_in_reg >= 5'd1) &&
                (day_in_reg <= days_in_month(mon_in_reg, year_in_reg)) &&
                (hour_in_reg < 5'(HOURS_PER_DAY)) && (min_in_reg <= 6'd59) &&
                (sec_in_reg <= 6'd59);
        year_off      = 8'(year_in_reg - YEAR_MIN);
        // Leap years before this one: multiples of four from 1904 up.
        leap_cnt_full = ((year_in_reg - 11'd1) >> 2) - 11'd475;
        leap_cnt      = (year_in_reg > YEAR_MIN) ? leap_cnt_full[5:0] : 6'd0;
        feb_adj       = is_leap(year_in_reg) && (mon_in_reg > 4'd2);
        sum_add       = {1'b0, acc_reg} + {3'b000, n_reg};
        // Reciprocal products for the day, hour and minute quotients.
        day_prod      = 53'(acc_reg[32:7]) * 53'(DAY_RECIP);
        hour_prod     = 27'(acc_reg[16:4]) * 27'(HOUR_RECIP);
        min_prod      = 21'(acc_reg[11:2]) * 21'(MIN_RECIP);
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        day_in_next     = day_in_reg;
        mon_in_next     = mon_in_reg;
        year_in_next    = year_in_reg;
        hour_in_next    = hour_in_reg;
        min_in_next     = min_in_reg;
        sec_in_next     = sec_in_reg;
        n_next          = n_reg;
        acc_next        = acc_reg;
        sod_next        = sod_reg;
        days_next       = days_reg;
        year_next       = year_reg;
        mon_next        = mon_reg;
        hour_next       = hour_reg;
        min_next        = min_reg;
        sec_next        = sec_reg;
        status_next     = status_reg;
        res_day_next    = res_day_reg;
        res_month_next  = res_month_reg;
        res_year_next   = res_year_reg;
        res_hour_next   = res_hour_reg;
        res_minute_next = res_minute_reg;
        res_second_next = res_second_reg;
        status_out_next = status_out_reg;
        load_out        = 1'b0;

        // The taker drains the output register.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op;
                    day_in_next  = day;
                    mon_in_next  = month;
                    year_in_next = year;
                    hour_in_next = hour;
                    min_in_next  = minute;
                    sec_in_next  = second;
                    n_next       = n_seconds;
                    state_next   = S_DAYS;
                end
            end

            S_DAYS:
            begin
                if (in_ok)
                begin
                    days_next = 16'(year_off) * 16'd365 + 16'(leap_cnt) +
                                16'(days_before_month(mon_in_reg)) + 16'(feb_adj) +
                                16'(day_in_reg) - 16'd1;
                    sod_next    = 17'(hour_in_reg) * 17'(HOUR_SECS) +
                                  17'(min_in_reg) * 17'(MIN_SECS) + 17'(sec_in_reg);
                    status_next = ST_OK;
                    state_next  = S_MUL;
                end
                else
                begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end
            end

            S_MUL:
            begin
                acc_next   = {17'd0, days_reg} * 33'(DAY_SECS) + {16'd0, sod_reg};
                state_next = S_ADD;
            end

            // Apply the offset and clamp to the calendar range.
            S_ADD:
            begin
                if (!op_reg)
                begin
                    if (sum_add > {1'b0, T_MAX})
                    begin
                        acc_next    = T_MAX;
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        acc_next = sum_add[32:0];
                    end
                end
                else if (alu_res.ge)
                begin
                    acc_next = alu_res.diff;
                end
                else
                begin
                    acc_next    = 33'd0;
                    status_next = ST_RANGE;
                end
                state_next = S_QDAY;
            end

            // Whole days in the instant.
            S_QDAY:
            begin
                days_next  = day_prod[DAY_RECIP_SHIFT +: 16];
                state_next = S_RDAY;
            end

            // Second of day left after the whole days.
            S_RDAY:
            begin
                acc_next   = alu_res.diff;
                year_next  = YEAR_MIN;
                state_next = S_YEAR;
            end

            // Step whole years off the day count.
            S_YEAR:
            begin
                if ((year_reg < YEAR_MAX) && alu_res.ge)
                begin
                    days_next = alu_res.diff[15:0];
                    year_next = year_reg + 11'd1;
                end
                else
                begin
                    mon_next   = 4'd1;
                    state_next = S_MON;
                end
            end

            // Step whole months off the day count.
            S_MON:
            begin
                if ((mon_reg < 4'd12) && alu_res.ge)
                begin
                    days_next = alu_res.diff[15:0];
                    mon_next  = mon_reg + 4'd1;
                end
                else
                begin
                    state_next = S_QHR;
                end
            end

            // Hour of the second of day.
            S_QHR:
            begin
                hour_next  = hour_prod[HOUR_RECIP_SHIFT +: 5];
                state_next = S_RHR;
            end

            // Seconds left within the hour.
            S_RHR:
            begin
                acc_next   = alu_res.diff;
                state_next = S_QMIN;
            end

            // Minute within the hour.
            S_QMIN:
            begin
                min_next   = min_prod[MIN_RECIP_SHIFT +: 6];
                state_next = S_RMIN;
            end

            // What is left after the minutes is the second.
            S_RMIN:
            begin
                sec_next   = alu_res.diff[5:0];
                state_next = S_DONE;
            end

            // Hand the item to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (load_out)
        begin
            status_out_next = status_reg;
            if (status_reg == ST_INVALID)
            begin
                res_day_next    = day_in_reg;
                res_month_next  = mon_in_reg;
                res_year_next   = year_in_reg;
                res_hour_next   = hour_in_reg;
                res_minute_next = min_in_reg;
                res_second_next = sec_in_reg;
            end
            else
            begin
                res_day_next    = 5'(days_reg + 16'd1);
                res_month_next  = mon_reg;
                res_year_next   = year_reg;
                res_hour_next   = hour_reg;
                res_minute_next = min_reg;
                res_second_next = sec_reg;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        day_in_reg     <= day_in_next;
        mon_in_reg     <= mon_in_next;
        year_in_reg    <= year_in_next;
        hour_in_reg    <= hour_in_next;
        min_in_reg     <= min_in_next;
        sec_in_reg     <= sec_in_next;
        n_reg          <= n_next;
        acc_reg        <= acc_next;
        sod_reg        <= sod_next;
        days_reg       <= days_next;
        year_reg       <= year_next;
        mon_reg        <= mon_next;
        hour_reg       <= hour_next;
        min_reg        <= min_next;
        sec_reg        <= sec_next;
        status_reg     <= status_next;
        res_day_reg    <= res_day_next;
        res_month_reg  <= res_month_next;
        res_year_reg   <= res_year_next;
        res_hour_reg   <= res_hour_next;
        res_minute_reg <= res_minute_next;
        res_second_reg <= res_second_next;
        status_out_reg <= status_out_next;
    end

    // Port drive.
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign res_day    = res_day_reg;
    assign res_month  = res_month_reg;
    assign res_year   = res_year_reg;
    assign res_hour   = res_hour_reg;
    assign res_minute = res_minute_reg;
    assign res_second = res_second_reg;
    assign status     = status_out_reg;

endmodule

`default_nettype wire

@@ src/dto_checker.sv @@
// Port-level checker for the datetime offset block, bound to its top level.
`default_nettype none

module dto_checker
    import dto_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [4:0]  res_day,
    input wire logic [3:0]  res_month,
    input wire logic [10:0] res_year,
    input wire logic [4:0]  res_hour,
    input wire logic [5:0]  res_minute,
    input wire logic [5:0]  res_second,
    input wire logic [1:0]  status
);

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_day) && $stable(res_month) &&
        $stable(res_year) && $stable(res_hour) && $stable(res_minute) &&
        $stable(res_second) && $stable(status))
        else $error("held result changed");

    // The block is busy right after it takes an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block ready right after accepting an item");

    // A normal result is a well-formed date and time inside the range.
    a_ok_well_formed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> res_day >= 5'd1 && res_month >= 4'd1 &&
        res_month <= 4'd12 && res_year >= YEAR_MIN && res_year <= YEAR_MAX &&
        res_hour <= 5'd23 && res_minute <= 6'd59 && res_second <= 6'd59)
        else $error("malformed normal result");

    // A clamped result sits exactly on one end of the range.
    a_range_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |->
        (res_year == YEAR_MIN && res_month == 4'd1 && res_day == 5'd1 &&
         res_hour == 5'd0 && res_minute == 6'd0 && res_second == 6'd0) ||
        (res_year == YEAR_MAX && res_month == 4'd12 && res_day == 5'd31 &&
         res_hour == 5'd23 && res_minute == 6'd59 && res_second == 6'd59))
        else $error("clamped result off the range limit");

    // No status code beyond the three defined ones.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_INVALID || status == ST_RANGE)
        else $error("undefined status code");

endmodule

bind datetime_offset_seconds_top dto_checker u_dto_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res_day    (res_day),
    .res_month  (res_month),
    .res_year   (res_year),
    .res_hour   (res_hour),
    .res_minute (res_minute),
    .res_second (res_second),
    .status     (status)
);

`default_nettype wire

@@ tb/sv/datetime_offset_seconds_top_tb.sv @@
// Self-checking testbench for the datetime offset block: queued items, random idling, result check.
module datetime_offset_seconds_top_tb;

    import dto_pkg::*;

    // Operation select on the op port.
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    localparam int RANDOM_ITEMS = 1350;
    localparam int MAX_WAIT     = 19;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        op;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [10:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [30:0] n_seconds;
    } request_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [10:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [1:0]  status;
    } stamp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [4:0]  day = '0;
    logic [3:0]  month = '0;
    logic [10:0] year = '0;
    logic [4:0]  hour = '0;
    logic [5:0]  minute = '0;
    logic [5:0]  second = '0;
    logic [30:0] n_seconds = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  res_day;
    logic [3:0]  res_month;
    logic [10:0] res_year;
    logic [4:0]  res_hour;
    logic [5:0]  res_minute;
    logic [5:0]  res_second;
    logic [1:0]  status;

    request_t pending_requests[$];
    stamp_t   shifted_expect[$];
    request_t driven_request;
    int       in_gap = 0;
    int       out_hold = 0;
    bit       in_quiet = 1'b0;
    bit       out_quiet = 1'b0;
    int       mismatch_count = 0;
    int       cycle_count = 0;

    datetime_offset_seconds_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .day        (day),
        .month      (month),
        .year       (year),
        .hour       (hour),
        .minute     (minute),
        .second     (second),
        .n_seconds  (n_seconds),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res_day    (res_day),
        .res_month  (res_month),
        .res_year   (res_year),
        .res_hour   (res_hour),
        .res_minute (res_minute),
        .res_second (res_second),
        .status     (status)
    );

    // Free-running clock, period 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Full Gregorian leap rule.
    function automatic bit is_leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int year_length(input int y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic int month_length(input int m, input int y);
        int len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    // Expected result: echo if invalid, else shift the time, clamp to the year range, split again.
    function automatic stamp_t shift_stamp(input request_t r);
        stamp_t  res;
        longint  t;
        longint  days;
        longint  rem;
        longint  t_last;
        int      y;
        int      m;
        bit      ok;
        ok = (r.month >= 1) && (r.month <= 12) && (r.year >= YEAR_MIN) && (r.year <= YEAR_MAX)
            && (r.day >= 1) && (r.day <= month_length(r.month, r.year))
            && (r.hour <= 23) && (r.minute <= 59) && (r.second <= 59);
        if (!ok)
        begin
            res = '{r.day, r.month, r.year, r.hour, r.minute, r.second, ST_INVALID};
            return res;
        end
        days = 0;
        for (y = YEAR_MIN; y < r.year; y++)
            days += year_length(y);
        for (m = 1; m < r.month; m++)
            days += month_length(m, r.year);
        days += r.day - 1;
        t = days * DAY_SECS + r.hour * 3600 + r.minute * 60 + r.second;
        t = (r.op == OP_SUB) ? t - longint'(r.n_seconds) : t + longint'(r.n_seconds);

        // Last second of 31/12 of the final year.
        t_last = 0;
        for (y = YEAR_MIN; y <= YEAR_MAX; y++)
            t_last += year_length(y);
        t_last = t_last * DAY_SECS - 1;

        res.status = ST_OK;
        if (t < 0)
        begin
            t = 0;
            res.status = ST_RANGE;
        end
        else if (t > t_last)
        begin
            t = t_last;
            res.status = ST_RANGE;
        end

        // Split the instant back into calendar fields.
        days = t / DAY_SECS;
        rem = t % DAY_SECS;
        y = YEAR_MIN;
        while (y < YEAR_MAX && days >= year_length(y))
        begin
            days -= year_length(y);
            y++;
        end
        m = 1;
        while (m < 12 && days >= month_length(m, y))
        begin
            days -= month_length(m, y);
            m++;
        end
        res.day = 5'(days + 1);
        res.month = 4'(m);
        res.year = 11'(y);
        res.hour = 5'(rem / 3600);
        res.minute = 6'((rem / 60) % 60);
        res.second = 6'(rem % 60);
        return res;
    endfunction

    // Wait length for the next item; quiet stretches have no idling at all.
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic queue_item(input logic o, input int d, input int mo, input int y,
                              input int h, input int mi, input int s, input logic [30:0] n);
        request_t r;
        r = '{o, 5'(d), 4'(mo), 11'(y), 5'(h), 6'(mi), 6'(s), n};
        pending_requests.push_back(r);
    endtask

    // One random item: mostly well-formed dates, some with one field broken, some raw noise.
    task automatic queue_random_item();
        int          kind;
        int          y;
        int          mo;
        int          d;
        int          h;
        int          mi;
        int          s;
        int          len;
        logic [30:0] n;
        kind = $urandom_range(0, 99);

        y = $urandom_range(YEAR_MIN, YEAR_MAX);
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 6))
                0: y = 1900;
                1: y = 1901;
                2: y = 1904;
                3: y = 2000;
                4: y = 2028;
                5: y = 2029;
                default: y = 2030;
            endcase
        end
        mo = $urandom_range(1, 12);
        len = month_length(mo, y);
        case ($urandom_range(0, 3))
            0: d = len;
            1: d = 1;
            default: d = $urandom_range(1, len);
        endcase
        case ($urandom_range(0, 5))
            0: begin h = 23; mi = 59; s = 59; end
            1: begin h = 0; mi = 0; s = 0; end
            default: begin h = $urandom_range(0, 23); mi = $urandom_range(0, 59);
                           s = $urandom_range(0, 59); end
        endcase

        case ($urandom_range(0, 5))
            0: n = 31'($urandom_range(0, 120));
            1: n = 31'($urandom_range(0, 200000));
            2: n = 31'($urandom_range(0, DAY_SECS * 60));
            3: n = 31'(DAY_SECS * $urandom_range(0, 800));
            default: n = 31'($urandom);
        endcase

        if (kind >= 85)
        begin
            // Raw noise over the full width of every field.
            d = $urandom_range(0, 31);
            mo = $urandom_range(0, 15);
            y = $urandom_range(0, 2047);
            h = $urandom_range(0, 31);
            mi = $urandom_range(0, 63);
            s = $urandom_range(0, 63);
        end
        else if (kind >= 70)
        begin
            // A well-formed date with exactly one field pushed out of its range.
            case ($urandom_range(0, 5))
                0: d = (len == 31) ? 0 : $urandom_range(len + 1, 31);
                1: mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
                2: y = $urandom_range(0, 1) ? $urandom_range(0, 1899) : $urandom_range(2031, 2047);
                3: h = $urandom_range(24, 31);
                4: mi = $urandom_range(60, 63);
                default: s = $urandom_range(60, 63);
            endcase
        end
        queue_item(1'($urandom_range(0, 1)), d, mo, y, h, mi, s, n);
    endtask

    // Driver: presents queued items, holds a stalled item, idles between items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            logic taken;
            taken = in_valid && !in_stall;
            if (taken)
            begin
                shifted_expect.push_back(shift_stamp(driven_request));
                in_gap = draw_wait(in_quiet);
            end
            else if (!in_valid && in_gap != 0)
                in_gap--;

            if ((taken || !in_valid) && in_gap == 0 && pending_requests.size() != 0)
            begin
                driven_request = pending_requests.pop_front();
                op <= driven_request.op;
                day <= driven_request.day;
                month <= driven_request.month;
                year <= driven_request.year;
                hour <= driven_request.hour;
                minute <= driven_request.minute;
                second <= driven_request.second;
                n_seconds <= driven_request.n_seconds;
                in_valid <= 1'b1;
            end
            else if (taken)
                in_valid <= 1'b0;
        end
    end

    // Monitor: takes results, checks them in order, then stalls the next one for a drawn count.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold = 0;
        end
        else
        begin
            stamp_t got;
            stamp_t want;
            got = '{res_day, res_month, res_year, res_hour, res_minute, res_second, status};
            if (out_valid && !out_stall)
            begin
                if (shifted_expect.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Unexpected result %0d/%0d/%0d %0d:%0d:%0d status %0d",
                                 got.day, got.month, got.year, got.hour, got.minute,
                                 got.second, got.status);
                end
                else
                begin
                    want = shifted_expect.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $write("Mismatch: expected %0d/%0d/%0d %0d:%0d:%0d status %0d,",
                                   want.day, want.month, want.year, want.hour,
                                   want.minute, want.second, want.status);
                            $display(" got %0d/%0d/%0d %0d:%0d:%0d status %0d",
                                     got.day, got.month, got.year, got.hour,
                                     got.minute, got.second, got.status);
                        end
                    end
                end
                out_hold = draw_wait(out_quiet);
            end
            else if (out_valid && out_hold != 0)
                out_hold--;
            out_stall <= (out_hold != 0);
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int i;

        // Range edges, zero offset and the largest offset both ways.
        queue_item(OP_ADD, 1, 1, 1900, 0, 0, 0, 31'd0);
        queue_item(OP_SUB, 1, 1, 1900, 0, 0, 0, 31'd1);
        queue_item(OP_ADD, 31, 12, 2030, 23, 59, 59, 31'd1);
        queue_item(OP_ADD, 31, 12, 2030, 23, 59, 59, 31'd0);
        queue_item(OP_SUB, 31, 12, 2030, 23, 59, 59, 31'h7FFFFFFF);
        queue_item(OP_ADD, 1, 1, 1900, 0, 0, 0, 31'h7FFFFFFF);
        queue_item(OP_SUB, 1, 1, 1900, 0, 0, 0, 31'h7FFFFFFF);
        // February carries in a century common year and in a leap year.
        queue_item(OP_ADD, 28, 2, 1900, 23, 59, 59, 31'd1);
        queue_item(OP_ADD, 28, 2, 2000, 23, 59, 59, 31'd1);
        queue_item(OP_SUB, 1, 3, 2000, 0, 0, 0, 31'd1);
        queue_item(OP_ADD, 31, 12, 1999, 23, 59, 59, 31'd1);
        queue_item(OP_ADD, 15, 6, 2024, 12, 30, 30, 31'(DAY_SECS * 365));
        // Invalid inputs are echoed.
        queue_item(OP_ADD, 29, 2, 2001, 10, 0, 0, 31'd5);
        queue_item(OP_ADD, 29, 2, 1900, 10, 0, 0, 31'd5);
        queue_item(OP_SUB, 31, 4, 2010, 10, 0, 0, 31'd5);
        queue_item(OP_ADD, 0, 5, 1950, 0, 0, 0, 31'd100);
        queue_item(OP_ADD, 10, 0, 1950, 0, 0, 0, 31'd100);
        queue_item(OP_SUB, 31, 15, 1950, 0, 0, 0, 31'h7FFFFFFF);
        queue_item(OP_ADD, 1, 1, 1899, 0, 0, 0, 31'd100);
        queue_item(OP_ADD, 1, 1, 2031, 0, 0, 0, 31'd100);
        queue_item(OP_ADD, 1, 1, 2047, 0, 0, 0, 31'd100);
        queue_item(OP_ADD, 1, 1, 0, 0, 0, 0, 31'd100);
        queue_item(OP_ADD, 1, 1, 1990, 24, 0, 0, 31'd100);
        queue_item(OP_SUB, 1, 1, 1990, 31, 63, 63, 31'd100);
        queue_item(OP_ADD, 1, 1, 1990, 12, 60, 60, 31'd100);

        for (i = 0; i < RANDOM_ITEMS; i++)
            queue_random_item();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() != 0 || in_valid || shifted_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
